### hdl/rc_pwm_pulse_period_capture_macros.svh
// Assertion macros shared by the RC PWM capture checker.
`ifndef RC_PWM_PULSE_PERIOD_CAPTURE_MACROS_SVH
`define RC_PWM_PULSE_PERIOD_CAPTURE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> cons) \
        else $error(msg);

`endif

### hdl/rcpc_pkg.sv
// Shared types, constants and helpers for the RC PWM pulse/period capture block.
package rcpc_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int OUTQ_DEPTH   = 4;

    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

    typedef enum logic [2:0] {
        REG_CHAN_COUNT   = 3'd0,
        REG_MIN_PULSE    = 3'd1,
        REG_MAX_PULSE    = 3'd2,
        REG_MIN_PERIOD   = 3'd3,
        REG_MAX_PERIOD   = 3'd4,
        REG_EDGE_TIMEOUT = 3'd5,
        REG_STALE        = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]  chan_count;
        logic [15:0] min_pulse;
        logic [15:0] max_pulse;
        logic [15:0] min_period;
        logic [15:0] max_period;
        logic [15:0] edge_timeout;
        logic [15:0] stale;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        chan_count:   3'd4,
        min_pulse:    16'd800,
        max_pulse:    16'd2200,
        min_period:   16'd2500,
        max_period:   16'd30000,
        edge_timeout: 16'd50,
        stale:        16'd100
    };

    typedef struct packed {
        logic [15:0] last_rise_tick;
        logic [15:0] pulse;
        logic [15:0] period;
        logic [15:0] pending;
        logic        pending_ok;
        logic [31:0] last_good_ms;
        logic [31:0] rise_stamp_ms;
        logic        awaiting_rise;
        logic        seen_rise;
        logic        valid;
    } t_chan_state;

    localparam t_chan_state STATE_RESET = '{
        last_rise_tick: 16'd0,
        pulse:          16'd0,
        period:         16'd0,
        pending:        16'd0,
        pending_ok:     1'b0,
        last_good_ms:   32'd0,
        rise_stamp_ms:  32'd0,
        awaiting_rise:  1'b1,
        seen_rise:      1'b0,
        valid:          1'b0
    };

    typedef struct packed {
        logic        ok;
        logic [15:0] pulse;
        logic [15:0] period;
    } t_result;

    function automatic logic in_window(input logic [15:0] v, input logic [15:0] lo,
                                       input logic [15:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

endpackage

### hdl/rc_pwm_pulse_period_capture.sv
// RC PWM pulse/period capture: top level with config regs, state RAM and pipeline.
// Throughput: one word per cycle while the output queue has room; the channel state
// RAM takes one read-modify-write per cycle, with the last write forwarded when
// back-to-back words hit the same channel. Reset: synchronous active low; config
// returns to defaults and per-channel entry valid flops clear, so every channel
// reads as its reset state at once (no clearing pass).
module rc_pwm_pulse_period_capture #(
    parameter int CHANNELS = rcpc_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // channel[1:0], capture_tick[17:2], now_ms[49:18]
    input  logic        s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ok[0], pulse_width_us[16:1], period[32:17]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int QD = rcpc_pkg::OUTQ_DEPTH;
    localparam int CW = $clog2(QD) + 1;
    localparam int SW = $bits(rcpc_pkg::t_chan_state);

    rcpc_pkg::t_cfg r_cfg;

    logic [1:0]    w_ch;
    logic [AW+1:0] w_ch_ext;
    logic [AW-1:0] w_addr;
    logic          w_in_range;
    logic          w_acc;

    logic          r_s1_vld;
    logic          r_s1_action;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_in;
    logic [15:0]   r_s1_tick;
    logic [31:0]   r_s1_now;
    logic          r_s1_evld;

    logic                  r_fw_vld;
    logic [AW-1:0]         r_fw_addr;
    rcpc_pkg::t_chan_state r_fw_data;

    logic [CHANNELS-1:0]   r_ent_vld;

    logic [SW-1:0]         w_rd_data;
    rcpc_pkg::t_chan_state w_cur;
    rcpc_pkg::t_chan_state w_next;
    logic                  w_upd_we;
    logic                  w_we;
    rcpc_pkg::t_result     w_res;
    rcpc_pkg::t_result     w_q_data;
    logic [CW-1:0]         w_q_count;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rcpc_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (rcpc_pkg::t_reg_idx'(i_cfg_index))
                rcpc_pkg::REG_CHAN_COUNT:   r_cfg.chan_count   <= i_cfg_data[2:0];
                rcpc_pkg::REG_MIN_PULSE:    r_cfg.min_pulse    <= i_cfg_data;
                rcpc_pkg::REG_MAX_PULSE:    r_cfg.max_pulse    <= i_cfg_data;
                rcpc_pkg::REG_MIN_PERIOD:   r_cfg.min_period   <= i_cfg_data;
                rcpc_pkg::REG_MAX_PERIOD:   r_cfg.max_period   <= i_cfg_data;
                rcpc_pkg::REG_EDGE_TIMEOUT: r_cfg.edge_timeout <= i_cfg_data;
                rcpc_pkg::REG_STALE:        r_cfg.stale        <= i_cfg_data;
                default:                    r_cfg              <= r_cfg;
            endcase
        end
    end

    assign w_ch       = s_axis_tdata[1:0];
    assign w_ch_ext   = {{AW{1'b0}}, w_ch};
    assign w_addr     = w_ch_ext[AW-1:0];
    assign w_in_range = (w_ch < r_cfg.chan_count[1:0] || r_cfg.chan_count[2])
                      && (w_ch_ext < (AW+2)'(CHANNELS));

    // room for the word in flight plus the new one
    assign s_axis_tready = ({1'b0, w_q_count} + {{CW{1'b0}}, r_s1_vld}) < (CW+1)'(QD);
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else begin
            r_s1_vld <= w_acc;
            r_fw_vld <= w_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_action <= s_axis_tuser;
            r_s1_addr   <= w_addr;
            r_s1_in     <= w_in_range;
            r_s1_tick   <= s_axis_tdata[17:2];
            r_s1_now    <= s_axis_tdata[49:18];
            r_s1_evld   <= w_in_range && r_ent_vld[w_addr];
        end
        if (w_we) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_we) begin
            r_ent_vld[r_s1_addr] <= 1'b1;
        end
    end

    rcpc_ram #(
        .WIDTH (SW),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (w_next),
        .i_re    (w_acc),
        .i_raddr (w_addr),
        .o_rdata (w_rd_data)
    );

    // write from the previous cycle is not yet visible in the RAM read
    always_comb begin
        if (r_fw_vld && (r_fw_addr == r_s1_addr)) begin
            w_cur = r_fw_data;
        end else if (r_s1_evld) begin
            w_cur = rcpc_pkg::t_chan_state'(w_rd_data);
        end else begin
            w_cur = rcpc_pkg::STATE_RESET;
        end
    end

    rcpc_update u_update (
        .i_cur      (w_cur),
        .i_action   (r_s1_action),
        .i_tick     (r_s1_tick),
        .i_now      (r_s1_now),
        .i_in_range (r_s1_in),
        .i_cfg      (r_cfg),
        .o_next     (w_next),
        .o_we       (w_upd_we),
        .o_res      (w_res)
    );

    assign w_we = r_s1_vld && w_upd_we;

    rcpc_outq #(
        .DEPTH (QD)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_vld),
        .i_data  (w_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign m_axis_tdata = {7'd0, w_q_data.period, w_q_data.pulse, w_q_data.ok};

endmodule

### hdl/rcpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rcpc_update.sv
// Per-channel edge/query update: next channel state and the result word.
module rcpc_update (
    input  rcpc_pkg::t_chan_state i_cur,
    input  logic                  i_action,
    input  logic [15:0]           i_tick,
    input  logic [31:0]           i_now,
    input  logic                  i_in_range,
    input  rcpc_pkg::t_cfg        i_cfg,
    output rcpc_pkg::t_chan_state o_next,
    output logic                  o_we,
    output rcpc_pkg::t_result     o_res
);

    logic [15:0] w_delta;
    logic [31:0] w_rise_age;
    logic [31:0] w_good_age;
    logic        w_per_ok;
    logic        w_pw_ok;
    logic        w_fresh;
    rcpc_pkg::t_chan_state w_nx;

    // Same 16-bit wrap difference serves as period on a rise and width on a fall
    assign w_delta    = i_tick - i_cur.last_rise_tick;
    assign w_rise_age = i_now - i_cur.rise_stamp_ms;
    assign w_good_age = i_now - i_cur.last_good_ms;
    assign w_per_ok   = rcpc_pkg::in_window(w_delta, i_cfg.min_period, i_cfg.max_period);
    assign w_pw_ok    = rcpc_pkg::in_window(w_delta, i_cfg.min_pulse, i_cfg.max_pulse);

    assign w_fresh = i_cur.valid
                   && !(!i_cur.awaiting_rise && (w_rise_age >= {16'd0, i_cfg.edge_timeout}))
                   && (w_good_age < {16'd0, i_cfg.stale});

    always_comb begin
        w_nx = i_cur;
        if (i_cur.awaiting_rise) begin
            if (i_cur.seen_rise) begin
                w_nx.pending    = w_delta;
                w_nx.pending_ok = w_per_ok;
                if (!w_per_ok) begin
                    w_nx.pulse      = 16'd0;
                    w_nx.period     = 16'd0;
                    w_nx.pending    = 16'd0;
                    w_nx.pending_ok = 1'b0;
                    w_nx.valid      = 1'b0;
                end
            end else begin
                w_nx.pending    = 16'd0;
                w_nx.pending_ok = 1'b0;
            end
            w_nx.last_rise_tick = i_tick;
            w_nx.rise_stamp_ms  = i_now;
            w_nx.seen_rise      = 1'b1;
            w_nx.awaiting_rise  = 1'b0;
        end else begin
            if (!w_pw_ok || ((i_cur.pending != 16'd0) && !i_cur.pending_ok)) begin
                w_nx.pulse      = 16'd0;
                w_nx.period     = 16'd0;
                w_nx.pending    = 16'd0;
                w_nx.pending_ok = 1'b0;
                w_nx.valid      = 1'b0;
            end else begin
                w_nx.pulse = w_delta;
                if (i_cur.pending_ok) begin
                    w_nx.period = i_cur.pending;
                end
                w_nx.last_good_ms = i_now;
                w_nx.valid        = 1'b1;
            end
            w_nx.awaiting_rise = 1'b1;
        end
    end

    always_comb begin
        o_res = '0;
        if (i_in_range) begin
            if (i_action == rcpc_pkg::ACT_QUERY) begin
                if (w_fresh) begin
                    o_res.ok     = 1'b1;
                    o_res.pulse  = i_cur.pulse;
                    o_res.period = i_cur.period;
                end
            end else begin
                o_res.ok     = w_nx.valid;
                o_res.pulse  = w_nx.pulse;
                o_res.period = w_nx.period;
            end
        end
    end

    assign o_next = w_nx;
    assign o_we   = i_in_range && (i_action == rcpc_pkg::ACT_CAPTURE);

endmodule

### hdl/rcpc_outq.sv
// Small result queue between the update stage and the output stream.
module rcpc_outq #(
    parameter int DEPTH = rcpc_pkg::OUTQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  rcpc_pkg::t_result          i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rcpc_pkg::t_result          o_data,
    output logic [$clog2(DEPTH):0]     o_count
);

    localparam int IW = $clog2(DEPTH);

    rcpc_pkg::t_result r_mem [DEPTH];
    logic [IW-1:0]     r_wp;
    logic [IW-1:0]     r_rp;
    logic [IW:0]       r_cnt;
    logic              w_pop;

    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

### hdl/rcpc_chk.sv
// Port-level checker for the RC PWM capture block, bound to the top level.
`include "rc_pwm_pulse_period_capture_macros.svh"

module rcpc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result word holds
    `RCPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, (m_axis_tvalid && $stable(m_axis_tdata)), "result word changed while stalled")

    // a channel that is not valid always carries cleared pulse and period
    `RCPC_ASSERT_NOW(a_nok_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], (m_axis_tdata[32:1] == 32'd0), "ok low with nonzero pulse or period")

    // input only backs up when results are waiting downstream
    `RCPC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid, "input stalled with empty output")

    // an accepted word into an empty pipe reaches m_axis through stage 1 and the result queue
    `RCPC_ASSERT_NOW(a_latency, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, (##2 m_axis_tvalid), "result missing two cycles after accept")

endmodule

bind rc_pwm_pulse_period_capture rcpc_chk u_rcpc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_rc_pwm_pulse_period_capture.sv
// Self-checking testbench for the RC PWM pulse/period capture block: directed and random words.
module tb_rc_pwm_pulse_period_capture;

    localparam int          CHANNELS     = rcpc_pkg::CHANNELS_DEF;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          CYCLE_LIMIT  = 250000;
    localparam logic [2:0]  REG_SPARE    = 3'd7;   // past the last register, must be ignored

    typedef struct packed {
        logic        action;
        logic [1:0]  chan;
        logic [15:0] tick;
        logic [31:0] now_ms;
    } t_pwm_word;

    typedef struct packed {
        logic [15:0] last_rise_tick;
        logic [15:0] pulse;
        logic [15:0] period;
        logic [15:0] pending;
        logic        pending_ok;
        logic [31:0] last_good_ms;
        logic [31:0] rise_stamp_ms;
        logic        awaiting_rise;
        logic        seen_rise;
        logic        valid;
    } t_chan_track;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // channel[1:0], capture_tick[17:2], now_ms[49:18]
    logic        s_axis_tuser  = 1'b0; // action[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // ok[0], pulse_width_us[16:1], period[32:17]
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [15:0] i_cfg_data    = '0;

    rc_pwm_pulse_period_capture u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state and register mirror
    rcpc_pkg::t_cfg    cfg;
    t_chan_track       chan_st [CHANNELS];

    t_pwm_word         pending_words[$];
    rcpc_pkg::t_result expected_results[$];
    t_pwm_word         in_flight;

    // stimulus bookkeeping: which edge each channel takes next
    logic        gen_next_rise [CHANNELS];
    logic [15:0] gen_rise_tick [CHANNELS];
    logic [31:0] gen_ms;

    int error_count   = 0;
    int words_taken   = 0;
    int queries_taken = 0;
    int ok_results    = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    logic [8:0] stall_cnt = '0;

    function automatic t_chan_track invalidate(input t_chan_track s);
        t_chan_track d;
        d            = s;
        d.pulse      = '0;
        d.period     = '0;
        d.pending    = '0;
        d.pending_ok = 1'b0;
        d.valid      = 1'b0;
        return d;
    endfunction

    // Updates the channel tracker for one word and returns the result it must produce.
    function automatic rcpc_pkg::t_result apply_word(input t_pwm_word w);
        rcpc_pkg::t_result r;
        t_chan_track       s;
        logic [15:0]       span;
        logic [31:0]       elapsed;
        logic              fresh;
        r = '0;
        if ({1'b0, w.chan} >= cfg.chan_count || int'(w.chan) >= CHANNELS)
            return r;
        s = chan_st[w.chan];
        if (w.action == rcpc_pkg::ACT_QUERY) begin
            fresh = s.valid;
            elapsed = w.now_ms - s.rise_stamp_ms;
            if (!s.awaiting_rise && elapsed >= {16'd0, cfg.edge_timeout})
                fresh = 1'b0;
            elapsed = w.now_ms - s.last_good_ms;
            if (elapsed >= {16'd0, cfg.stale})
                fresh = 1'b0;
            if (fresh) begin
                r.ok     = 1'b1;
                r.pulse  = s.pulse;
                r.period = s.period;
            end
            return r;
        end
        span = w.tick - s.last_rise_tick;
        if (s.awaiting_rise) begin
            if (s.seen_rise) begin
                s.pending    = span;
                s.pending_ok = (span >= cfg.min_period) && (span <= cfg.max_period);
                if (!s.pending_ok)
                    s = invalidate(s);
            end else begin
                s.pending    = '0;
                s.pending_ok = 1'b0;
            end
            s.last_rise_tick = w.tick;
            s.rise_stamp_ms  = w.now_ms;
            s.seen_rise      = 1'b1;
            s.awaiting_rise  = 1'b0;
        end else begin
            if (span < cfg.min_pulse || span > cfg.max_pulse
                    || (s.pending != 16'd0 && !s.pending_ok)) begin
                s = invalidate(s);
            end else begin
                s.pulse = span;
                if (s.pending_ok)
                    s.period = s.pending;
                s.last_good_ms = w.now_ms;
                s.valid        = 1'b1;
            end
            s.awaiting_rise = 1'b1;
        end
        chan_st[w.chan] = s;
        r.ok     = s.valid;
        r.pulse  = s.pulse;
        r.period = s.period;
        return r;
    endfunction

    // Mostly inside the window, sometimes on or just past its edges, now and then anything.
    function automatic logic [15:0] pick_span(input logic [15:0] lo, input logic [15:0] hi);
        case ($urandom_range(0, 19))
            0:       return lo;
            1:       return hi;
            2:       return lo - 16'd1;
            3:       return hi + 16'd1;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(int'(lo), int'(hi)));
        endcase
    endfunction

    task automatic add_word(input logic act, input logic [1:0] ch, input logic [15:0] tick,
                            input logic [31:0] ms);
        t_pwm_word w;
        w = '{action: act, chan: ch, tick: tick, now_ms: ms};
        pending_words.push_back(w);
        if (act == rcpc_pkg::ACT_CAPTURE && {1'b0, ch} < cfg.chan_count) begin
            if (gen_next_rise[ch])
                gen_rise_tick[ch] = tick;
            gen_next_rise[ch] = !gen_next_rise[ch];
        end
    endtask

    task automatic add_random_words(input int n);
        int          sel;
        logic [1:0]  ch;
        logic [15:0] span;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            ch  = 2'($urandom_range(0, 3));
            gen_ms += 32'($urandom_range(0, 6));
            if ($urandom_range(0, 40) == 0)
                gen_ms += 32'($urandom_range(40, 400));
            if (sel < 62) begin
                // next edge of a plausible pulse train
                if (gen_next_rise[ch])
                    span = pick_span(cfg.min_period, cfg.max_period);
                else
                    span = pick_span(cfg.min_pulse, cfg.max_pulse);
                add_word(rcpc_pkg::ACT_CAPTURE, ch, gen_rise_tick[ch] + span, gen_ms);
            end else if (sel < 88) begin
                add_word(rcpc_pkg::ACT_QUERY, ch, 16'($urandom), gen_ms);
            end else begin
                add_word(1'($urandom), 2'($urandom), 16'($urandom), $urandom);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            rcpc_pkg::REG_CHAN_COUNT:   cfg.chan_count   = val[2:0];
            rcpc_pkg::REG_MIN_PULSE:    cfg.min_pulse    = val;
            rcpc_pkg::REG_MAX_PULSE:    cfg.max_pulse    = val;
            rcpc_pkg::REG_MIN_PERIOD:   cfg.min_period   = val;
            rcpc_pkg::REG_MAX_PERIOD:   cfg.max_period   = val;
            rcpc_pkg::REG_EDGE_TIMEOUT: cfg.edge_timeout = val;
            rcpc_pkg::REG_STALE:        cfg.stale        = val;
            default: ;
        endcase
    endtask

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(apply_word(in_flight));
                words_taken++;
                if (in_flight.action == rcpc_pkg::ACT_QUERY)
                    queries_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    in_flight     <= pending_words[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, pending_words[0].now_ms, pending_words[0].tick,
                                      pending_words[0].chan};
                    s_axis_tuser  <= pending_words[0].action;
                    void'(pending_words.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: receiver stall pattern is chosen by bits 8:7 of stall_cnt
    always @(posedge i_clk) begin
        rcpc_pkg::t_result exp_r;
        logic    got_ok;
        logic [15:0] got_pulse, got_period;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            stall_cnt <= stall_cnt + 9'd1;
            case (stall_cnt[8:7])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_axis_tready <= (stall_cnt[3:0] >= 4'd6);
                default: m_axis_tready <= 1'($urandom);
            endcase
            if (m_axis_tvalid && m_axis_tready) begin
                got_ok     = m_axis_tdata[0];
                got_pulse  = m_axis_tdata[16:1];
                got_period = m_axis_tdata[32:17];
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result ok=%0b pulse=%0d period=%0d",
                             $time, got_ok, got_pulse, got_period);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_ok) ok_results++;
                    if (got_ok !== exp_r.ok) begin
                        error_count++;
                        $display("%0t: ok expected %0b got %0b", $time, exp_r.ok, got_ok);
                    end
                    if (got_pulse !== exp_r.pulse) begin
                        error_count++;
                        $display("%0t: pulse_width_us expected %0d got %0d",
                                 $time, exp_r.pulse, got_pulse);
                    end
                    if (got_period !== exp_r.period) begin
                        error_count++;
                        $display("%0t: period expected %0d got %0d",
                                 $time, exp_r.period, got_period);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not drain within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [15:0] r1, r2, r3, r4, r5;
        logic [15:0] lo, span;
        cfg = rcpc_pkg::CFG_RESET;
        for (int c = 0; c < CHANNELS; c++) begin
            chan_st[c]               = '0;
            chan_st[c].awaiting_rise = 1'b1;
            gen_next_rise[c]         = 1'b1;
            gen_rise_tick[c]         = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: wrap of the tick, window edges, timeout and staleness, far channel
        r1 = 16'hFFF0 + 16'd20000;
        r2 = r1 + 16'd2500;
        r3 = r2 + 16'd30000;
        r4 = r3 + 16'd30001;
        r5 = r4 + 16'd2499;
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd5);    // never valid
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, 16'hFFF0,      32'd10);   // first rise
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, 16'h05CC,      32'd11);   // fall across the wrap
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd20);
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r1,            32'd30);
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd79);   // one ms short of timeout
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd80);   // fall timed out
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r1 + 16'd800,  32'd81);   // shortest pulse
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd180);
        add_word(rcpc_pkg::ACT_QUERY,   2'd0, 16'd0,         32'd181);  // stale
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r2,            32'd190);  // shortest period
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r2 + 16'd2200, 32'd191);  // longest pulse
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r3,            32'd200);  // longest period
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r3 + 16'd2201, 32'd201);  // pulse too long
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r4,            32'd210);  // period too long
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r4 + 16'd1000, 32'd211);  // good pulse, no period
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r5,            32'd220);  // period too short
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd0, r5 + 16'd799,  32'd221);  // pulse too short
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd3, 16'd0,         32'd230);
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd3, 16'd1234,      32'd231);
        add_word(rcpc_pkg::ACT_QUERY,   2'd3, 16'hFFFF,      32'd232);
        add_word(rcpc_pkg::ACT_QUERY,   2'd2, 16'd0,         32'd232);
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd1, 16'hFFFF,      32'hFFFF_FFFF);
        add_word(rcpc_pkg::ACT_CAPTURE, 2'd1, 16'd899,       32'd0);    // ms wraps
        add_word(rcpc_pkg::ACT_QUERY,   2'd1, 16'd0,         32'd49);
        wait_idle();

        gen_ms = 32'd1000;
        add_random_words(180);
        wait_idle();

        // widest windows, no timeout allowance, two channels
        set_reg(rcpc_pkg::REG_CHAN_COUNT,   16'd2);
        set_reg(rcpc_pkg::REG_MIN_PULSE,    16'd0);
        set_reg(rcpc_pkg::REG_MAX_PULSE,    16'hFFFF);
        set_reg(rcpc_pkg::REG_MIN_PERIOD,   16'd0);
        set_reg(rcpc_pkg::REG_MAX_PERIOD,   16'hFFFF);
        set_reg(rcpc_pkg::REG_EDGE_TIMEOUT, 16'd0);
        set_reg(rcpc_pkg::REG_STALE,        16'hFFFF);
        set_reg(REG_SPARE,                  16'hA5A5);
        add_random_words(150);
        wait_idle();

        // nothing in use, then more channels than exist
        set_reg(rcpc_pkg::REG_CHAN_COUNT, 16'd0);
        set_reg(rcpc_pkg::REG_STALE,      16'd0);
        add_random_words(40);
        wait_idle();
        set_reg(rcpc_pkg::REG_CHAN_COUNT,   16'd7);
        set_reg(rcpc_pkg::REG_STALE,        16'd300);
        set_reg(rcpc_pkg::REG_EDGE_TIMEOUT, 16'hFFFF);
        set_reg(rcpc_pkg::REG_MIN_PULSE,    16'd900);
        set_reg(rcpc_pkg::REG_MAX_PULSE,    16'd2000);
        set_reg(rcpc_pkg::REG_MIN_PERIOD,   16'd3000);
        set_reg(rcpc_pkg::REG_MAX_PERIOD,   16'd25000);
        add_random_words(120);
        wait_idle();

        // inverted windows accept nothing
        set_reg(rcpc_pkg::REG_CHAN_COUNT, 16'd3);
        set_reg(rcpc_pkg::REG_MIN_PULSE,  16'd3000);
        set_reg(rcpc_pkg::REG_MAX_PULSE,  16'd1000);
        set_reg(rcpc_pkg::REG_MIN_PERIOD, 16'd40000);
        set_reg(rcpc_pkg::REG_MAX_PERIOD, 16'd100);
        add_random_words(60);
        wait_idle();

        // random settings, ms counter close to its wrap
        gen_ms = 32'hFFFF_FE00;
        for (int k = 0; k < 3; k++) begin
            set_reg(rcpc_pkg::REG_CHAN_COUNT, 16'($urandom_range(1, 4)));
            lo = 16'($urandom_range(0, 1500));
            span = 16'($urandom_range(0, 3000));
            set_reg(rcpc_pkg::REG_MIN_PULSE, lo);
            set_reg(rcpc_pkg::REG_MAX_PULSE, lo + span);
            lo = 16'($urandom_range(0, 8000));
            span = 16'($urandom_range(0, 30000));
            set_reg(rcpc_pkg::REG_MIN_PERIOD, lo);
            set_reg(rcpc_pkg::REG_MAX_PERIOD, lo + span);
            set_reg(rcpc_pkg::REG_EDGE_TIMEOUT, 16'($urandom_range(1, 200)));
            set_reg(rcpc_pkg::REG_STALE,        16'($urandom_range(1, 400)));
            add_random_words(100);
            wait_idle();
        end

        $display("Covered %0d words (%0d queries, %0d ok results) over eight register settings,",
                 words_taken, queries_taken, ok_results);
        $display("including empty, oversized and inverted configurations.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/rcpc_pkg.sv
hdl/rcpc_ram.sv
hdl/rcpc_update.sv
hdl/rcpc_outq.sv
hdl/rc_pwm_pulse_period_capture.sv
hdl/rcpc_chk.sv
verif/tb_rc_pwm_pulse_period_capture.sv
